// ===== hdl/stable_sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define SSPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSPQ_ASSERT(lbl, prop, msg)
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/sspq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Sizes, request and status codes, and the types shared by the cell row.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int QUEUE_DEPTH    = 64;
  localparam int TASK_ID_BITS   = 16;
  localparam int KEY_BITS       = 64;
  localparam int COUNT_BITS     = 7;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 7;
  localparam int IN_TDATA_BITS  = 88;
  localparam int OUT_TDATA_BITS = 48;

  localparam logic [KEY_BITS-1:0] FIFO_KEY = '1;

  // The last code is not a request; it is refused as invalid.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIFO_MODE = 1'b0,
    CFG_CAPACITY  = 1'b1
  } cfg_idx_t;

  // One queue entry.
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [TASK_ID_BITS-1:0] task_id;
  } entry_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [KEY_BITS-1:0]     new_key;
    logic [TASK_ID_BITS-1:0] new_task;
  } cell_ctrl_t;

endpackage

// ===== hdl/sspq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue cell
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's; on delete it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module sspq_cell
  import sspq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  logic       left_le,
  input  logic       shift,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output entry_t     entry_next,
  output logic       le,
  output logic       match
);

  // Compare flags seen by the neighbor and the control.
  assign le    = valid && (entry.key <= ctrl.new_key);
  assign match = valid && (entry.task_id == ctrl.new_task);

  // Insert goes after every key less than or equal, so ties keep arrival order.
  always_comb begin
    entry_next = entry;
    if (ctrl.ins && !le) begin
      if (left_le) begin
        entry_next.key     = ctrl.new_key;
        entry_next.task_id = ctrl.new_task;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.del && shift) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Top level: request decode, cell row, counters and the result register.
// ----------------------------------------------------------------------------
// Each request beat is finished in the cycle it is accepted: all 64 cells
// compare their key and id against the request at once and shift in one step,
// so the block takes one beat per cycle while results are taken, and the
// result beat is registered and shown in the cycle after the request. Entries
// are sorted by key, equal keys in arrival order; an entry outside the current
// count holds stale data and is never reported.
module stable_sorted_priority_queue
  import sspq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // mode[1:0], task_id[17:2], sort_key[81:18], zero fill
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[2:0], popped_task[18:3], head_task[34:19], head_valid[35],
  // entry_count[42:36], zero fill
  output logic [OUT_TDATA_BITS-1:0] m_tdata
);

  `include "stable_sorted_priority_queue_defines.svh"

  logic                     fifo_mode;
  logic [COUNT_BITS-1:0]    capacity_limit;
  logic [COUNT_BITS-1:0]    occupancy;
  logic [COUNT_BITS-1:0]    occupancy_next;
  logic [KEY_BITS-1:0]      arrival_sequence;

  logic [1:0]               in_mode;
  logic [TASK_ID_BITS-1:0]  in_task;
  logic [KEY_BITS-1:0]      in_key;
  logic                     accept;

  cell_ctrl_t               ctrl;
  entry_t                   entries      [QUEUE_DEPTH];
  entry_t                   entries_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   le_vec;
  logic [QUEUE_DEPTH-1:0]   match_vec;
  logic [QUEUE_DEPTH-1:0]   valid_vec;
  logic [QUEUE_DEPTH-1:0]   shift_vec;

  status_t                  status;
  logic                     ins_ok;
  logic                     pop_ok;
  logic                     rem_ok;
  logic                     fifo_ins;
  logic                     full;
  logic                     found;
  logic [TASK_ID_BITS-1:0]  popped;

  // Unpack the request beat.
  assign in_mode = s_tdata[1:0];
  assign in_task = s_tdata[17:2];
  assign in_key  = s_tdata[81:18];
  assign accept  = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_mode      <= 1'b0;
      capacity_limit <= COUNT_BITS'(QUEUE_DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIFO_MODE: fifo_mode      <= cfg_data[0];
        CFG_CAPACITY:  capacity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request checks.
  assign full     = (occupancy >= capacity_limit) ||
                    (occupancy >= COUNT_BITS'(QUEUE_DEPTH));
  assign found    = |match_vec;
  assign fifo_ins = (in_key == FIFO_KEY);

  always_comb begin
    status = ST_INVALID;
    ins_ok = 1'b0;
    pop_ok = 1'b0;
    rem_ok = 1'b0;
    unique case (mode_t'(in_mode))
      MODE_INSERT: begin
        priority if (in_task == '0) begin
          status = ST_INVALID;
        end else if (full) begin
          status = ST_FULL;
        end else if (fifo_ins != fifo_mode) begin
          status = ST_INVALID;
        end else begin
          status = ST_OK;
          ins_ok = 1'b1;
        end
      end
      MODE_POP: begin
        if (occupancy == '0) begin
          status = ST_EMPTY;
        end else begin
          status = ST_OK;
          pop_ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        priority if (in_task == '0) begin
          status = ST_INVALID;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          status = ST_OK;
          rem_ok = 1'b1;
        end
      end
      default: status = ST_INVALID;
    endcase
  end

  // Broadcast to the cells; a FIFO insert uses the arrival sequence as key.
  assign ctrl.ins      = accept && ins_ok;
  assign ctrl.del      = accept && (pop_ok || rem_ok);
  assign ctrl.new_key  = fifo_ins ? arrival_sequence : in_key;
  assign ctrl.new_task = in_task;

  // Cell row.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_le;

    assign valid_vec[i] = COUNT_BITS'(i) < occupancy;
    // A delete shifts every cell from the first match on; a pop from the head.
    assign shift_vec[i] = pop_ok || (|match_vec[i:0]);

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = entries[i];
    end else begin : g_inner
      assign left_le    = le_vec[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid_vec[i]),
      .left_le     (left_le),
      .shift       (shift_vec[i]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .entry_next  (entries_next[i]),
      .le          (le_vec[i]),
      .match       (match_vec[i])
    );
  end

  // Count and sequence.
  always_comb begin
    occupancy_next = occupancy;
    if (ctrl.ins) begin
      occupancy_next = occupancy + COUNT_BITS'(1);
    end else if (ctrl.del) begin
      occupancy_next = occupancy - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy        <= '0;
      arrival_sequence <= '0;
    end else begin
      occupancy <= occupancy_next;
      if (ctrl.ins && fifo_ins) begin
        arrival_sequence <= arrival_sequence + KEY_BITS'(1);
      end
    end
  end

  // Result beat register.
  assign popped = pop_ok ? entries[0].task_id : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, occupancy_next, (occupancy_next != '0),
                  (occupancy_next != '0) ? entries_next[0].task_id : TASK_ID_BITS'(0),
                  popped, status};
    end
  end

  // Checks.
  `SSPQ_ASSERT(a_occ_bound, occupancy <= COUNT_BITS'(QUEUE_DEPTH), "count over depth")
  `SSPQ_ASSERT(a_occ_idle, !accept |=> $stable(occupancy), "count moved without a beat")
  `SSPQ_ASSERT(a_result_follows, accept |=> m_tvalid, "no result after request")
  `SSPQ_ASSERT(a_head_flag, m_tvalid |-> (m_tdata[35] == (m_tdata[42:36] != '0)),
               "head flag disagrees with count")

endmodule
